// ===== sv/assert_macros.svh =====
// Assertion macros shared by the cubic B-spline basis evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CBB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CBB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks an invariant at every clock edge out of reset.
`define CBB_ASSERT_ALW(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== sv/cbb_pkg.sv =====
// Types and constants shared by the cubic B-spline basis evaluator modules.
package cbb_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_NORM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INTERVALS = 3'd4;

    // Field widths.
    localparam int NORM_W = 18;
    localparam int NINT_W = 6;
    // Scaled position width, wide enough for the largest fraction width and basis count.
    localparam int UW     = 33;

    // Configuration reset values.
    localparam logic signed [31:0] RST_INTERVAL_MIN  = -32'sd65536;
    localparam logic signed [31:0] RST_INTERVAL_MAX  = 32'sd65536;
    localparam logic [31:0]        RST_INV_SPACING   = 32'd327680;
    localparam logic [NORM_W-1:0]  RST_INV_NORM      = 18'd32768;
    localparam logic [NINT_W-1:0]  RST_NUM_INTERVALS = 6'd10;

    // Configuration register set.
    typedef struct packed {
        logic signed [31:0] interval_min;
        logic signed [31:0] interval_max;
        logic [31:0]        inv_spacing;
        logic [NORM_W-1:0]  inv_norm;
        logic [NINT_W-1:0]  num_intervals;
    } t_cfg;

    // One classified argument waiting for evaluation.
    typedef struct packed {
        logic signed [UW-1:0] u;
        logic signed [31:0]   c;
        logic                 is_inside;
    } t_item;

    // Sideband that travels with one basis evaluation.
    typedef struct packed {
        logic [5:0]         idx;
        logic signed [31:0] c;
        logic               is_inside;
        logic               last;
    } t_tag;

    // Segment of the cubic B-spline that a position falls in.
    typedef enum logic [1:0] {
        SEG_ZERO,
        SEG_OUTER,
        SEG_INNER
    } t_seg;

endpackage

// ===== sv/cbb_front.sv =====
// Front end: accepts arguments, clamps them and scales them to knot units.
module cbb_front import cbb_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int MAX_BASIS   = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_argument,
    input  t_cfg               i_cfg,
    input  logic               i_pop,
    output logic               o_push,
    output t_item              o_item
);

    localparam int OCCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] CAP = 64'(MAX_BASIS + 8) << FRAC_BITS;

    logic               w_accept;
    logic [OCCW-1:0]    r_occ;
    logic [OCCW-1:0]    n_occ;

    logic               r_f1_v;
    logic signed [31:0] r_f1_c;
    logic               r_f1_inside;
    logic signed [31:0] n_f1_c;
    logic               n_f1_inside;

    logic               r_f2_v;
    logic [31:0]        r_f2_mag;
    logic               r_f2_neg;
    logic signed [31:0] r_f2_c;
    logic               r_f2_inside;
    logic signed [32:0] n_f2_diff;

    logic               r_f3_v;
    logic [63:0]        r_f3_prod;
    logic               r_f3_neg;
    logic signed [31:0] r_f3_c;
    logic               r_f3_inside;
    logic [63:0]        w_pos;
    logic [63:0]        w_sat;

    // Items in flight count against the queue so that a push always finds room.
    assign o_busy   = (r_occ == OCCW'(QUEUE_DEPTH));
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_occ = r_occ;
        if (w_accept && !i_pop) begin
            n_occ = r_occ + OCCW'(1);
        end else if (!w_accept && i_pop) begin
            n_occ = r_occ - OCCW'(1);
        end
    end

    // Clamp to the interval; the lower bound is checked first.
    always_comb begin
        n_f1_c      = i_argument;
        n_f1_inside = 1'b1;
        if (i_argument < i_cfg.interval_min) begin
            n_f1_c      = i_cfg.interval_min;
            n_f1_inside = 1'b0;
        end else if (i_argument > i_cfg.interval_max) begin
            n_f1_c      = i_cfg.interval_max;
            n_f1_inside = 1'b0;
        end
    end

    // Offset from the lower bound, split into sign and magnitude.
    assign n_f2_diff = {r_f1_c[31], r_f1_c} - {i_cfg.interval_min[31], i_cfg.interval_min};

    // Scaled position, saturated in magnitude.
    always_comb begin
        w_pos = r_f3_prod >> FRAC_BITS;
        w_sat = (w_pos > CAP) ? CAP : w_pos;
    end

    assign o_push           = r_f3_v;
    assign o_item.u         = r_f3_neg ? -UW'(w_sat) : UW'(w_sat);
    assign o_item.c         = r_f3_c;
    assign o_item.is_inside = r_f3_inside;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_f1_v <= w_accept;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        r_f1_c      <= n_f1_c;
        r_f1_inside <= n_f1_inside;

        r_f2_neg    <= n_f2_diff[32];
        r_f2_mag    <= n_f2_diff[32] ? 32'(-n_f2_diff) : n_f2_diff[31:0];
        r_f2_c      <= r_f1_c;
        r_f2_inside <= r_f1_inside;

        r_f3_prod   <= 64'(r_f2_mag) * 64'(i_cfg.inv_spacing);
        r_f3_neg    <= r_f2_neg;
        r_f3_c      <= r_f2_c;
        r_f3_inside <= r_f2_inside;
    end

endmodule

// ===== sv/cbb_queue.sv =====
// Short queue of classified arguments between the front and back ends.
`include "assert_macros.svh"
module cbb_queue import cbb_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `CBB_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_count != CW'(DEPTH), "queue overflow")
    `CBB_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "queue underflow")
    `CBB_ASSERT_ALW(a_count_range, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count out of range")

endmodule

// ===== sv/cbb_back.sv =====
// Back end: walks the basis functions of each argument and evaluates one per cycle.
`include "assert_macros.svh"
module cbb_back import cbb_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_BASIS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_pop,
    output logic               o_strobe,
    output logic [5:0]         o_basis_index,
    output logic signed [39:0] o_basis_value,
    output logic signed [47:0] o_basis_slope,
    output logic signed [31:0] o_clamped_arg,
    output logic               o_inside_res,
    output logic               o_last
);

    localparam int TW  = FRAC_BITS + $clog2(2 * MAX_BASIS + 8) + 1;
    localparam int YW  = FRAC_BITS + 1;
    localparam int VW  = FRAC_BITS + 4;
    localparam int NW  = VW + NORM_W - FRAC_BITS;
    localparam int SPW = NW + 32;
    localparam logic [TW-1:0] ONE_T  = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] TWO_T  = TW'(2) << FRAC_BITS;
    localparam logic [VW-1:0] FOUR_V = VW'(4) << FRAC_BITS;
    localparam logic [39:0]   ONE_40 = 40'(1) << FRAC_BITS;
    localparam logic [6:0]    MAXB   = 7'(MAX_BASIS);

    // Basis counter.
    logic        r_act;
    logic [5:0]  r_idx;
    logic [5:0]  r_last_idx;
    t_item       r_cur;
    logic        w_done;
    logic [6:0]  n_count;
    logic [5:0]  n_last_idx;

    // Stage 1: position and segment.
    logic [TW-1:0] n_t;
    logic [TW-1:0] n_x;
    logic          n_neg;
    t_seg          n_seg;
    logic [YW-1:0] n_y;
    t_tag          n_tag;
    logic          r_p1_v;
    t_tag          r_p1_tag;
    t_seg          r_p1_seg;
    logic          r_p1_neg;
    logic [YW-1:0] r_p1_y;

    // Stage 2: square.
    logic [2*YW-1:0] n_p2_sq;
    logic            r_p2_v;
    t_tag            r_p2_tag;
    t_seg            r_p2_seg;
    logic            r_p2_neg;
    logic [YW-1:0]   r_p2_y;
    logic [YW-1:0]   r_p2_y2;

    // Stage 3: cube.
    logic [2*YW-1:0] n_p3_cu;
    logic            r_p3_v;
    t_tag            r_p3_tag;
    t_seg            r_p3_seg;
    logic            r_p3_neg;
    logic [YW-1:0]   r_p3_y;
    logic [YW-1:0]   r_p3_y2;
    logic [YW-1:0]   r_p3_y3;

    // Stage 4: polynomial value and slope magnitude.
    logic [VW-1:0] n_ye;
    logic [VW-1:0] n_y2e;
    logic [VW-1:0] n_y3e;
    logic [VW-1:0] n_p4_val;
    logic [VW-1:0] n_p4_dmag;
    logic          r_p4_v;
    t_tag          r_p4_tag;
    logic          r_p4_neg;
    logic [VW-1:0] r_p4_val;
    logic [VW-1:0] r_p4_dmag;

    // Stage 5: normalization.
    logic [VW+NORM_W-1:0] n_p5_vprod;
    logic [VW+NORM_W-1:0] n_p5_sprod;
    logic                 r_p5_v;
    t_tag                 r_p5_tag;
    logic                 r_p5_neg;
    logic [NW-1:0]        r_p5_vn;
    logic [NW-1:0]        r_p5_sn;

    // Stage 6: spacing scale and output register.
    logic [SPW-1:0] n_p6_prod;
    logic [47:0]    n_p6_mag;
    logic [47:0]    n_p6_slope;
    logic [39:0]    n_p6_value;
    logic           r_strobe;
    logic [5:0]     r_index;
    logic [39:0]    r_value;
    logic [47:0]    r_slope;
    logic [31:0]    r_clamped;
    logic           r_inside;
    logic           r_last;

    // Take the next argument as the current one issues its final basis.
    assign w_done = r_act && (r_idx == r_last_idx);
    assign o_pop  = i_q_valid && (!r_act || w_done);

    always_comb begin
        n_count = 7'(i_cfg.num_intervals) + 7'd4;
        if (n_count > MAXB) begin
            n_count = MAXB;
        end
        n_last_idx = 6'(n_count - 7'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_pop) begin
            r_act <= 1'b1;
        end else if (w_done) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx      <= '0;
            r_cur      <= i_q_item;
            r_last_idx <= n_last_idx;
        end else if (r_act && !w_done) begin
            r_idx <= r_idx + 6'd1;
        end
    end

    // Position relative to this basis center, folded to its magnitude.
    always_comb begin
        n_t   = TW'(r_cur.u) + TWO_T - (TW'(r_idx) << FRAC_BITS);
        n_neg = n_t[TW-1];
        n_x   = n_neg ? -n_t : n_t;
        n_y   = '0;
        if (n_x > TWO_T) begin
            n_seg = SEG_ZERO;
        end else if (n_x >= ONE_T) begin
            n_seg = SEG_OUTER;
            n_y   = YW'(TWO_T - n_x);
        end else begin
            n_seg = SEG_INNER;
            n_y   = YW'(n_x);
        end
        n_tag.idx       = r_idx;
        n_tag.c         = r_cur.c;
        n_tag.is_inside = r_cur.is_inside;
        n_tag.last      = w_done;
    end

    assign n_p2_sq = (2*YW)'(r_p1_y) * (2*YW)'(r_p1_y);
    assign n_p3_cu = (2*YW)'(r_p2_y2) * (2*YW)'(r_p2_y);

    // Outer segment: (2-x)^3 with slope 3(2-x)^2; inner: 4-6x^2+3x^3 with slope 12x-9x^2.
    always_comb begin
        n_ye  = VW'(r_p3_y);
        n_y2e = VW'(r_p3_y2);
        n_y3e = VW'(r_p3_y3);
        case (r_p3_seg)
            SEG_OUTER: begin
                n_p4_val  = n_y3e;
                n_p4_dmag = (n_y2e << 1) + n_y2e;
            end
            SEG_INNER: begin
                n_p4_val  = FOUR_V + (n_y3e << 1) + n_y3e - (n_y2e << 2) - (n_y2e << 1);
                n_p4_dmag = (n_ye << 3) + (n_ye << 2) - (n_y2e << 3) - n_y2e;
            end
            default: begin
                n_p4_val  = '0;
                n_p4_dmag = '0;
            end
        endcase
    end

    assign n_p5_vprod = (VW+NORM_W)'(r_p4_val) * (VW+NORM_W)'(i_cfg.inv_norm);
    assign n_p5_sprod = (VW+NORM_W)'(r_p4_dmag) * (VW+NORM_W)'(i_cfg.inv_norm);

    // The unsigned slope is falling for positive positions, so the slope takes the opposite sign.
    always_comb begin
        n_p6_prod  = SPW'(r_p5_sn) * SPW'(i_cfg.inv_spacing);
        n_p6_mag   = 48'(n_p6_prod >> FRAC_BITS);
        n_p6_slope = r_p5_neg ? n_p6_mag : -n_p6_mag;
        n_p6_value = 40'(r_p5_vn);
        if (r_p5_tag.idx == 6'd0) begin
            n_p6_value = ONE_40;
            n_p6_slope = '0;
        end
        if (!r_p5_tag.is_inside) begin
            n_p6_slope = '0;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_p3_v   <= 1'b0;
            r_p4_v   <= 1'b0;
            r_p5_v   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_p1_v   <= r_act;
            r_p2_v   <= r_p1_v;
            r_p3_v   <= r_p2_v;
            r_p4_v   <= r_p3_v;
            r_p5_v   <= r_p4_v;
            r_strobe <= r_p5_v;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_p1_tag  <= n_tag;
        r_p1_seg  <= n_seg;
        r_p1_neg  <= n_neg;
        r_p1_y    <= n_y;

        r_p2_tag  <= r_p1_tag;
        r_p2_seg  <= r_p1_seg;
        r_p2_neg  <= r_p1_neg;
        r_p2_y    <= r_p1_y;
        r_p2_y2   <= n_p2_sq[FRAC_BITS +: YW];

        r_p3_tag  <= r_p2_tag;
        r_p3_seg  <= r_p2_seg;
        r_p3_neg  <= r_p2_neg;
        r_p3_y    <= r_p2_y;
        r_p3_y2   <= r_p2_y2;
        r_p3_y3   <= n_p3_cu[FRAC_BITS +: YW];

        r_p4_tag  <= r_p3_tag;
        r_p4_neg  <= r_p3_neg;
        r_p4_val  <= n_p4_val;
        r_p4_dmag <= n_p4_dmag;

        r_p5_tag  <= r_p4_tag;
        r_p5_neg  <= r_p4_neg;
        r_p5_vn   <= n_p5_vprod[FRAC_BITS +: NW];
        r_p5_sn   <= n_p5_sprod[FRAC_BITS +: NW];

        r_index   <= r_p5_tag.idx;
        r_value   <= n_p6_value;
        r_slope   <= n_p6_slope;
        r_clamped <= r_p5_tag.c;
        r_inside  <= r_p5_tag.is_inside;
        r_last    <= r_p5_tag.last;
    end

    assign o_strobe      = r_strobe;
    assign o_basis_index = r_index;
    assign o_basis_value = r_value;
    assign o_basis_slope = r_slope;
    assign o_clamped_arg = r_clamped;
    assign o_inside_res  = r_inside;
    assign o_last        = r_last;

    `CBB_ASSERT_NXT(a_burst_steps, i_clk, i_rst_n, r_strobe && !r_last, r_strobe && (r_index == $past(r_index) + 6'd1), "basis burst broken")
    `CBB_ASSERT_NXT(a_next_starts_at_zero, i_clk, i_rst_n, r_strobe && r_last, !r_strobe || (r_index == 6'd0), "new burst does not start at basis zero")
    `CBB_ASSERT_IMP(a_outside_flat, i_clk, i_rst_n, r_strobe && !r_inside, r_slope == '0, "slope nonzero outside the interval")

endmodule

// ===== sv/cubic_bspline_basis_eval.sv =====
// Uniform cubic B-spline basis evaluator: configuration registers and top level.
//
// Usage: an argument word is taken at a clock edge where start is high and busy is
// low. For every argument the block emits num_intervals + 4 result words (capped at
// MAX_BASIS), basis 0 first, one per cycle, each marked by o_res_strobe for one cycle;
// o_last flags the final word of an argument. The receiver cannot stall, so words must
// be taken as they appear.
// Throughput: the basis counter issues one basis per cycle into a six-stage multiply
// pipeline and starts the next queued argument as the current one issues its final basis.
// The front end clamps and scales arguments into a QUEUE_DEPTH entry queue; busy
// rises when QUEUE_DEPTH arguments are accepted but not yet started.
// Configuration: the write channel is always ready; a word with an unknown index is
// dropped. The user must change registers only with no argument in flight; unchecked.
// Reset: synchronous, active low; clears the queue and pipeline and loads the
// default configuration.
module cubic_bspline_basis_eval import cbb_pkg::*; #(
    parameter int MAX_BASIS   = 64,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_argument,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_res_strobe,
    output logic [5:0]           o_basis_index,
    output logic signed [39:0]   o_basis_value,
    output logic signed [47:0]   o_basis_slope,
    output logic signed [31:0]   o_clamped_arg,
    output logic                 o_inside_res,
    output logic                 o_last
);

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_push_item;
    t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_min  <= RST_INTERVAL_MIN;
            r_cfg.interval_max  <= RST_INTERVAL_MAX;
            r_cfg.inv_spacing   <= RST_INV_SPACING;
            r_cfg.inv_norm      <= RST_INV_NORM;
            r_cfg.num_intervals <= RST_NUM_INTERVALS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INTERVAL_MIN:  r_cfg.interval_min  <= i_cfg_data;
                CFG_INTERVAL_MAX:  r_cfg.interval_max  <= i_cfg_data;
                CFG_INV_SPACING:   r_cfg.inv_spacing   <= i_cfg_data;
                CFG_INV_NORM:      r_cfg.inv_norm      <= i_cfg_data[NORM_W-1:0];
                CFG_NUM_INTERVALS: r_cfg.num_intervals <= i_cfg_data[NINT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cbb_front #(
        .FRAC_BITS   (FRAC_BITS),
        .MAX_BASIS   (MAX_BASIS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_argument (i_argument),
        .i_cfg      (r_cfg),
        .i_pop      (w_pop),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    cbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    cbb_back #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_BASIS (MAX_BASIS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_pop         (w_pop),
        .o_strobe      (o_res_strobe),
        .o_basis_index (o_basis_index),
        .o_basis_value (o_basis_value),
        .o_basis_slope (o_basis_slope),
        .o_clamped_arg (o_clamped_arg),
        .o_inside_res  (o_inside_res),
        .o_last        (o_last)
    );

endmodule
